// ----- rtl/csc_pkg.sv -----
package csc_pkg;

  localparam int unsigned CSC_ITERATIONS = 16;
  localparam int unsigned CSC_MAX_ITER   = 16;
  localparam int unsigned CSC_W          = 16;
  localparam int unsigned CSC_RESID_W    = 14;

  localparam logic signed [CSC_W-1:0] CSC_GAIN_INIT = 16'sh4DBA;
  localparam logic signed [CSC_W-1:0] CSC_Q15_MAX   = 16'sh7FFF;
  localparam logic signed [CSC_W-1:0] CSC_Q15_MIN   = 16'sh8000;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } csc_quad_t;

  // one item as it moves down the rotation pipeline
  typedef struct packed {
    csc_quad_t               quad;
    logic signed [CSC_W-1:0] ang;
    logic signed [CSC_W-1:0] x;
    logic signed [CSC_W-1:0] y;
  } csc_beat_t;

  // arctangent of 2^-i, full turn = 65536
  function automatic logic signed [CSC_W-1:0] csc_atan(input logic [3:0] idx);
    logic signed [CSC_W-1:0] v;
    case (idx)
      4'd0:    v = 16'sh2000;
      4'd1:    v = 16'sh12E4;
      4'd2:    v = 16'sh09FB;
      4'd3:    v = 16'sh0511;
      4'd4:    v = 16'sh028B;
      4'd5:    v = 16'sh0146;
      4'd6:    v = 16'sh00A3;
      4'd7:    v = 16'sh0051;
      4'd8:    v = 16'sh0029;
      4'd9:    v = 16'sh0014;
      4'd10:   v = 16'sh000A;
      4'd11:   v = 16'sh0005;
      4'd12:   v = 16'sh0003;
      4'd13:   v = 16'sh0001;
      4'd14:   v = 16'sh0001;
      default: v = 16'sh0000;
    endcase
    return v;
  endfunction

  // clamp a 17-bit sum to q15
  function automatic logic signed [CSC_W-1:0] csc_sat(input logic signed [CSC_W:0] v);
    logic signed [CSC_W-1:0] r;
    if (v[CSC_W] != v[CSC_W-1]) begin
      r = v[CSC_W] ? CSC_Q15_MIN : CSC_Q15_MAX;
    end else begin
      r = v[CSC_W-1:0];
    end
    return r;
  endfunction

  // saturating negation
  function automatic logic signed [CSC_W-1:0] csc_neg(input logic signed [CSC_W-1:0] v);
    return csc_sat(-{v[CSC_W-1], v});
  endfunction

endpackage

// ----- rtl/cordic_sine_cosine_top.sv -----
// channel  | dir | tdata bits, lowest first            | tuser | tlast
// s_axis   | in  | phase[15:0] (unsigned, 0x4000=90deg) | -     | -
// m_axis   | out | cosine[15:0], sine[15:0] (q15)      | -     | -
//
// one beat per clock sustained while m_axis does not stall
// each cordic micro-rotation is its own register stage, then one output stage
// rst clears only the valid bits; payload registers are not reset
// a stall at m_axis freezes the pipeline, the output skid register keeps
// s_tready high for the cycle in which the stall is first seen
module cordic_sine_cosine_top
  import csc_pkg::*;
#(
  parameter int unsigned ITERATIONS = CSC_ITERATIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // phase[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // cosine[15:0], sine[31:16]
);

  // valid/ready/beat between stages; index ITERATIONS feeds the output stage
  logic      stg_valid [ITERATIONS+1];
  logic      stg_ready [ITERATIONS+1];
  csc_beat_t stg_beat  [ITERATIONS+1];

  logic signed [CSC_W-1:0] cos_o;
  logic signed [CSC_W-1:0] sin_o;

  // entry: split phase into quadrant and residual, start from the gain constant
  always_comb begin
    stg_valid[0]     = s_tvalid;
    stg_beat[0].quad = csc_quad_t'(s_tdata[CSC_W-1:CSC_RESID_W]);
    stg_beat[0].ang  = {{(CSC_W-CSC_RESID_W){1'b0}}, s_tdata[CSC_RESID_W-1:0]};
    stg_beat[0].x    = CSC_GAIN_INIT;
    stg_beat[0].y    = '0;
  end
  assign s_tready = stg_ready[0];

  // one micro-rotation per register stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    csc_stage #(
      .IDX (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_beat   (stg_beat[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_beat  (stg_beat[i+1])
    );
  end

  // quadrant fold plus output register with skid
  csc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[ITERATIONS]),
    .in_ready  (stg_ready[ITERATIONS]),
    .in_beat   (stg_beat[ITERATIONS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_cos   (cos_o),
    .out_sin   (sin_o)
  );

  assign m_tdata = {sin_o, cos_o};

endmodule

// ----- rtl/csc_stage.sv -----
module csc_stage
  import csc_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  csc_beat_t in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output csc_beat_t out_beat
);

  localparam logic [3:0] SHIFT = 4'(IDX % CSC_MAX_ITER);

  logic                    valid;
  csc_beat_t               beat;
  csc_beat_t               beat_next;
  logic signed [CSC_W-1:0] xs;
  logic signed [CSC_W-1:0] ys;
  logic signed [CSC_W-1:0] step;

  assign in_ready = !valid || out_ready;

  always_comb begin
    xs   = in_beat.x >>> SHIFT;
    ys   = in_beat.y >>> SHIFT;
    step = csc_atan(SHIFT);
    beat_next.quad = in_beat.quad;
    if (!in_beat.ang[CSC_W-1]) begin
      beat_next.x   = csc_sat({in_beat.x[CSC_W-1], in_beat.x} - {ys[CSC_W-1], ys});
      beat_next.y   = csc_sat({in_beat.y[CSC_W-1], in_beat.y} + {xs[CSC_W-1], xs});
      beat_next.ang = in_beat.ang - step;
    end else begin
      beat_next.x   = csc_sat({in_beat.x[CSC_W-1], in_beat.x} + {ys[CSC_W-1], ys});
      beat_next.y   = csc_sat({in_beat.y[CSC_W-1], in_beat.y} - {xs[CSC_W-1], xs});
      beat_next.ang = in_beat.ang + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat <= beat_next;
    end
  end

  assign out_valid = valid;
  assign out_beat  = beat;

endmodule

// ----- rtl/csc_out.sv -----
module csc_out
  import csc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  csc_beat_t               in_beat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CSC_W-1:0] out_cos,
  output logic signed [CSC_W-1:0] out_sin
);

  logic                    valid;
  logic signed [CSC_W-1:0] cos_q;
  logic signed [CSC_W-1:0] sin_q;
  logic                    skid_valid;
  logic signed [CSC_W-1:0] skid_cos;
  logic signed [CSC_W-1:0] skid_sin;
  logic signed [CSC_W-1:0] cos_next;
  logic signed [CSC_W-1:0] sin_next;

  // fold the rotated vector back into its quadrant
  always_comb begin
    case (in_beat.quad)
      QUAD_0: begin
        cos_next = in_beat.x;
        sin_next = in_beat.y;
      end
      QUAD_1: begin
        cos_next = csc_neg(in_beat.y);
        sin_next = in_beat.x;
      end
      QUAD_2: begin
        cos_next = csc_neg(in_beat.x);
        sin_next = csc_neg(in_beat.y);
      end
      default: begin
        cos_next = in_beat.y;
        sin_next = csc_neg(in_beat.x);
      end
    endcase
  end

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !valid) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !valid) begin
      if (skid_valid) begin
        cos_q <= skid_cos;
        sin_q <= skid_sin;
      end else if (in_valid) begin
        cos_q <= cos_next;
        sin_q <= sin_next;
      end
    end else if (in_valid && in_ready) begin
      skid_cos <= cos_next;
      skid_sin <= sin_next;
    end
  end

  assign out_valid = valid;
  assign out_cos   = cos_q;
  assign out_sin   = sin_q;

endmodule

// ----- rtl/csc_checker.sv -----
module csc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  // backpressure at input only while a result is waiting at the output
  a_bp_has_out: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

  // input stalls only after the output was stalled the cycle before
  a_bp_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output stall");

endmodule

bind cordic_sine_cosine_top csc_checker u_csc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import csc_pkg::*;

  localparam int unsigned RANDOM_PHASES = 1100;
  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned DRAIN_CYCLES  = 2 * CSC_ITERATIONS + 8;

  // arctangent of 2^-i, full turn = 65536
  localparam logic signed [15:0] ATAN_STEP [16] = '{
    16'sh2000, 16'sh12E4, 16'sh09FB, 16'sh0511,
    16'sh028B, 16'sh0146, 16'sh00A3, 16'sh0051,
    16'sh0029, 16'sh0014, 16'sh000A, 16'sh0005,
    16'sh0003, 16'sh0001, 16'sh0001, 16'sh0000
  };

  typedef struct packed {
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
  } sincos_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // phase[15:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // cosine[15:0], sine[31:16]

  logic [15:0] phase_q[$];
  sincos_t     sincos_q[$];
  int unsigned err_cnt = 0;
  int unsigned src_hold = 0;
  int unsigned snk_hold = 0;
  bit          src_steady = 1'b0;
  bit          snk_steady = 1'b0;
  int unsigned idle_cnt = 0;

  cordic_sine_cosine_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic int q15_clamp(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // rotate the gain-compensated unit vector by the residual angle, then fold by quadrant
  function automatic sincos_t cordic_rotate(input logic [15:0] phase);
    csc_quad_t          quad;
    logic signed [15:0] resid;
    int                 x, y, xs, ys, xn, yn, c, s, i;
    sincos_t            r;
    quad  = csc_quad_t'(phase[15:14]);
    resid = {2'b00, phase[13:0]};
    x     = int'(CSC_GAIN_INIT);
    y     = 0;
    for (i = 0; i < CSC_ITERATIONS; i++) begin
      xs = x >>> (i % 16);
      ys = y >>> (i % 16);
      if (resid >= 0) begin
        xn    = q15_clamp(x - ys);
        yn    = q15_clamp(y + xs);
        resid = resid - ATAN_STEP[i % 16];
      end else begin
        xn    = q15_clamp(x + ys);
        yn    = q15_clamp(y - xs);
        resid = resid + ATAN_STEP[i % 16];
      end
      x = xn;
      y = yn;
    end
    case (quad)
      QUAD_0: begin
        c = x;
        s = y;
      end
      QUAD_1: begin
        c = q15_clamp(-y);
        s = x;
      end
      QUAD_2: begin
        c = q15_clamp(-x);
        s = q15_clamp(-y);
      end
      default: begin
        c = y;
        s = q15_clamp(-x);
      end
    endcase
    r.cosine = c[15:0];
    r.sine   = s[15:0];
    return r;
  endfunction

  // mostly short gaps, a few long ones, none at all in steady stretches
  function automatic int unsigned idle_len(input bit steady);
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady || roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // phase driver: on each accepted beat log its expected sin/cos, then maybe idle
  always @(posedge clk) begin : src_drive
    bit fire;
    fire = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sincos_q.push_back(cordic_rotate(s_tdata));
        src_hold = idle_len(src_steady);
        if ($urandom_range(63) == 0) src_steady = !src_steady;
        fire = (src_hold == 0) && (phase_q.size() != 0);
      end else if (!s_tvalid) begin
        if (src_hold != 0) src_hold--;
        fire = (src_hold == 0) && (phase_q.size() != 0);
      end
      if (fire) begin
        s_tvalid <= 1'b1;
        s_tdata  <= phase_q.pop_front();
      end else if (s_tvalid && s_tready) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink backpressure
  always @(posedge clk) begin
    if (!rst) begin
      if (snk_hold == 0) begin
        snk_hold = idle_len(snk_steady);
        if ($urandom_range(63) == 0) snk_steady = !snk_steady;
      end else begin
        snk_hold--;
      end
      m_tready <= (snk_hold == 0);
    end
  end

  // result monitor: compare each beat with the oldest expected pair
  always @(posedge clk) begin : res_check
    sincos_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (sincos_q.size() == 0) begin
        $display("%0t: unexpected beat cosine=%0d sine=%0d", $time, got.cosine, got.sine);
        err_cnt++;
      end else begin
        want = sincos_q.pop_front();
        if (got.cosine !== want.cosine) begin
          $display("%0t: cosine expected %0d actual %0d", $time, want.cosine, got.cosine);
          err_cnt++;
        end
        if (got.sine !== want.sine) begin
          $display("%0t: sine expected %0d actual %0d", $time, want.sine, got.sine);
          err_cnt++;
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin : stimulus
    logic [15:0] acc;
    logic [15:0] step;
    int unsigned n, roll, run;
    // quadrant edges, residual extremes, octant point, alternating bits
    phase_q = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF,
                16'h7FFF, 16'hBFFF, 16'h0001, 16'h4001, 16'h8001, 16'hC001,
                16'h2000, 16'h6000, 16'hA000, 16'hE000, 16'h1FFF, 16'h2001,
                16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
    acc = 16'($urandom_range(65535));
    n   = 0;
    while (n < RANDOM_PHASES) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        phase_q.push_back(16'($urandom_range(65535)));
        n++;
      end else if (roll < 65) begin
        // near a quadrant boundary, either side
        phase_q.push_back(16'(($urandom_range(3) << 14) + $urandom_range(16) - 8));
        n++;
      end else if (roll < 80) begin
        // near the octant midpoint of a quadrant
        phase_q.push_back(16'(($urandom_range(3) << 14) + 16'h2000 + $urandom_range(64) - 32));
        n++;
      end else begin
        // phase accumulator run
        step = (roll < 90) ? 16'($urandom_range(255, 1)) : 16'($urandom_range(65535));
        run  = $urandom_range(32, 4);
        repeat (run) begin
          acc = acc + step;
          phase_q.push_back(acc);
          n++;
        end
      end
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // poll between edges so driver and monitor updates have all settled
    do @(negedge clk);
    while (phase_q.size() != 0 || s_tvalid || sincos_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- cordic_sine_cosine_top.f -----
rtl/csc_pkg.sv
rtl/csc_stage.sv
rtl/csc_out.sv
rtl/cordic_sine_cosine_top.sv
rtl/csc_checker.sv
test/tb_top.sv
